>>> sv/itp_pkg.sv
// itp_pkg: shared types, character codes and helper function for the
// infix to postfix converter. No dependencies.
package itp_pkg;

  // ascii codes of the special characters
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_Z     = 8'h7A;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_TERM  = 8'h00;

  typedef enum logic [2:0] {
    CLS_LETTER,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_ADDSUB,
    CLS_OTHER
  } sym_class_t;

  typedef enum logic [1:0] {
    SRC_SYM,
    SRC_TOP,
    SRC_ZERO
  } emit_src_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAIN,
    ST_FLUSH,
    ST_DONE
  } itp_state_t;

  // controller to datapath
  typedef struct packed {
    logic      ready;
    logic      push;
    logic      pop;
    logic      emit;
    emit_src_t src;
    logic      finish;
  } itp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       in_valid;
    sym_class_t cls;
    logic       last;
    logic       empty;
    logic       top_open;
    logic       top_addsub;
    logic       pend_valid;
    logic       out_free;
  } itp_status_t;

  function automatic sym_class_t classify(input logic [7:0] ch);
    sym_class_t c;
    if (ch >= CH_A && ch <= CH_Z) c = CLS_LETTER;
    else if (ch == CH_OPEN) c = CLS_OPEN;
    else if (ch == CH_CLOSE) c = CLS_CLOSE;
    else if (ch == CH_PLUS || ch == CH_MINUS) c = CLS_ADDSUB;
    else c = CLS_OTHER;
    return c;
  endfunction

endpackage

>>> sv/itp_if.sv
// itp_if: valid/ready stream interfaces for input characters and
// postfix results. No dependencies.
interface itp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol_in;
  logic       end_of_expr;

  modport source (output valid, output symbol_in, output end_of_expr, input ready);
  modport sink (input valid, input symbol_in, input end_of_expr, output ready);
endinterface

interface itp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol_out;
  logic       last_of_run;

  modport source (output valid, output symbol_out, output last_of_run, input ready);
  modport sink (input valid, input symbol_out, input last_of_run, output ready);
endinterface

>>> sv/itp_ctrl.sv
// itp_ctrl: state machine sequencing pushes, pops and emits per character.
// Depends on itp_pkg.
module itp_ctrl
  import itp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  itp_status_t st,
  output itp_cmd_t    cmd
);

  itp_state_t state, state_next;
  logic       can_emit;
  logic       main_done;

  // an emit needs the staging slot, or room to move it out
  assign can_emit = !st.pend_valid || st.out_free;

  // main phase finishes this cycle
  always_comb begin
    main_done = 1'b0;
    unique case (st.cls)
      CLS_LETTER: main_done = can_emit;
      CLS_OPEN:   main_done = 1'b1;
      CLS_CLOSE:  main_done = st.empty || st.top_open;
      CLS_ADDSUB: main_done = st.empty || st.top_open;
      CLS_OTHER:  main_done = st.empty || st.top_open || st.top_addsub;
      default:    main_done = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (st.in_valid) state_next = ST_MAIN;
      end
      ST_MAIN: begin
        if (main_done) state_next = st.last ? ST_FLUSH : ST_DONE;
      end
      ST_FLUSH: begin
        if (st.empty && can_emit) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!st.pend_valid || st.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    cmd.src = SRC_SYM;
    unique case (state)
      ST_IDLE: begin
        cmd.ready = 1'b1;
      end
      ST_MAIN: begin
        unique case (st.cls)
          CLS_LETTER: begin
            cmd.emit = can_emit;
            cmd.src  = SRC_SYM;
          end
          CLS_OPEN: begin
            cmd.push = 1'b1;
          end
          CLS_CLOSE: begin
            if (!st.empty) begin
              if (st.top_open) begin
                cmd.pop = 1'b1;
              end else if (can_emit) begin
                cmd.pop  = 1'b1;
                cmd.emit = 1'b1;
                cmd.src  = SRC_TOP;
              end
            end
          end
          CLS_ADDSUB, CLS_OTHER: begin
            if (main_done) begin
              cmd.push = 1'b1;
            end else if (can_emit) begin
              cmd.pop  = 1'b1;
              cmd.emit = 1'b1;
              cmd.src  = SRC_TOP;
            end
          end
          default: ;
        endcase
      end
      ST_FLUSH: begin
        if (can_emit) begin
          cmd.emit = 1'b1;
          if (st.empty) begin
            cmd.src = SRC_ZERO;
          end else begin
            cmd.pop = 1'b1;
            cmd.src = SRC_TOP;
          end
        end
      end
      ST_DONE: begin
        cmd.finish = st.pend_valid && st.out_free;
      end
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> sv/itp_datapath.sv
// itp_datapath: operator stack memory, character register, staging and
// output registers. Depends on itp_pkg and the stream interfaces.
module itp_datapath
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  itp_in_if.sink       in_stream,
  itp_out_if.source    out_stream,
  input  itp_cmd_t     cmd,
  output itp_status_t  st
);

  localparam int IdxW = $clog2(STACK_DEPTH);
  localparam int CntW = $clog2(STACK_DEPTH + 1);

  logic [7:0]      stack_mem [STACK_DEPTH];
  logic [CntW-1:0] count, count_next;
  logic [IdxW-1:0] rd_addr;
  logic [7:0]      top;
  logic [7:0]      sym;
  logic            last;
  logic [7:0]      pend_sym;
  logic            pend_valid;
  logic [7:0]      out_sym;
  logic            out_last;
  logic            out_valid;
  logic [7:0]      emit_val;
  logic            do_push;
  logic            load;

  assign load    = in_stream.valid && in_stream.ready;
  assign do_push = cmd.push && (count < CntW'(STACK_DEPTH));

  // stack depth tracking
  always_comb begin
    count_next = count;
    if (do_push) count_next = count + CntW'(1);
    else if (cmd.pop) count_next = count - CntW'(1);
  end

  // top entry address after this cycle's update
  assign rd_addr = (count_next == '0) ? '0 : IdxW'(count_next - CntW'(1));

  // stack memory, registered top read with write bypass
  always_ff @(posedge clk) begin
    if (do_push) stack_mem[IdxW'(count)] <= sym;
    if (do_push && (IdxW'(count) == rd_addr)) top <= sym;
    else top <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // accepted character
  always_ff @(posedge clk) begin
    if (load) begin
      sym  <= in_stream.symbol_in;
      last <= in_stream.end_of_expr;
    end
  end

  // emitted value select
  always_comb begin
    unique case (cmd.src)
      SRC_SYM:  emit_val = sym;
      SRC_TOP:  emit_val = top;
      SRC_ZERO: emit_val = CH_TERM;
      default:  emit_val = CH_TERM;
    endcase
  end

  // staging register holds a result until it is known whether more follow
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.emit) begin
      pend_valid <= 1'b1;
    end else if (cmd.finish) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) pend_sym <= emit_val;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.emit && pend_valid) || cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.emit && pend_valid) || cmd.finish) begin
      out_sym  <= pend_sym;
      out_last <= cmd.finish;
    end
  end

  assign out_stream.valid       = out_valid;
  assign out_stream.symbol_out  = out_sym;
  assign out_stream.last_of_run = out_last;
  assign in_stream.ready        = cmd.ready;

  // status to controller
  always_comb begin
    st.in_valid   = in_stream.valid;
    st.cls        = classify(sym);
    st.last       = last;
    st.empty      = (count == '0);
    st.top_open   = (top == CH_OPEN);
    st.top_addsub = (top == CH_PLUS) || (top == CH_MINUS);
    st.pend_valid = pend_valid;
    st.out_free   = !out_valid || out_stream.ready;
  end

endmodule

>>> sv/infix_to_postfix_converter_unit.sv
// Infix to postfix converter: takes one ASCII character per transaction and
// returns the postfix characters it causes, one per transaction, with
// last_of_run marking the final result of each input character. Lowercase
// letters pass through, operators go through a STACK_DEPTH-entry stack, and
// a character with end_of_expr set flushes the stack and adds a zero
// terminator. Each character is accepted in the idle state, then a main phase
// pops stack entries one at a time and then pushes an operator or emits a
// letter; with end_of_expr a flush phase pops the remaining entries and emits
// the terminator, and a closing state releases the last result. A result the
// output side does not take stalls these phases. The stack memory has one
// write and one registered top read, which sets one pop per cycle while the
// output side keeps up. Results pass through a staging and an output
// register; the next character is accepted only after the last result of the
// current one has moved into the output register.
module infix_to_postfix_converter_unit
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  itp_in_if.sink    in_stream,
  itp_out_if.source out_stream
);

  itp_cmd_t    cmd;
  itp_status_t st;

  itp_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  itp_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .in_stream  (in_stream),
    .out_stream (out_stream),
    .cmd        (cmd),
    .st         (st)
  );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for infix_to_postfix_converter_unit. A directed table is
// followed by random expressions, each checked against a behavioral operator stack.
// Depends on itp_pkg and the itp_in_if / itp_out_if stream interfaces.
module tb;
  import itp_pkg::*;

  localparam int STACK_DEPTH  = 32;
  localparam int DRILL_COUNT  = 25;
  localparam int RANDOM_ITEMS = 255;
  localparam int CHOKE_CYCLES = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 2000000;

  // one postfix character as it leaves the block
  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } postfix_t;

  // directed row: typed rows carry their own results, the rest use the stack model
  typedef struct packed {
    logic [7:0]      sym;
    logic            eoe;
    logic            typed;
    logic [2:0]      nres;
    logic [0:3][7:0] res;
  } drill_row_t;

  logic clk = 1'b0;
  logic rst;

  itp_in_if  infix_ch ();
  itp_out_if postfix_ch ();

  infix_to_postfix_converter_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_stream (infix_ch),
    .out_stream(postfix_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // behavioral operator stack
  logic [7:0] op_stack [STACK_DEPTH];
  int         op_depth = 0;
  postfix_t   step_out [$];
  postfix_t   postfix_due [$];
  logic [7:0] expr_buf [$];

  int mismatch_cnt = 0;
  int result_cnt   = 0;
  int items_sent   = 0;
  int cycle_cnt    = 0;
  bit choke_req    = 1'b0;
  bit sink_steady  = 1'b0;
  bit send_burst   = 1'b0;

  // directed table: extremes, every character class, stack corner cases
  drill_row_t drill_rows [DRILL_COUNT] = '{
    '{CH_A,     1'b0, 1'b1, 3'd1, {CH_A, CH_TERM, CH_TERM, CH_TERM}},
    '{CH_Z,     1'b0, 1'b1, 3'd1, {CH_Z, CH_TERM, CH_TERM, CH_TERM}},
    '{CH_PLUS,  1'b0, 1'b1, 3'd0, '0},
    '{"b",      1'b0, 1'b1, 3'd1, {"b", CH_TERM, CH_TERM, CH_TERM}},
    '{"*",      1'b0, 1'b0, 3'd0, '0},
    '{"c",      1'b0, 1'b1, 3'd1, {"c", CH_TERM, CH_TERM, CH_TERM}},
    '{CH_MINUS, 1'b0, 1'b1, 3'd2, {"*", CH_PLUS, CH_TERM, CH_TERM}},
    '{CH_OPEN,  1'b0, 1'b1, 3'd0, '0},
    '{"d",      1'b0, 1'b1, 3'd1, {"d", CH_TERM, CH_TERM, CH_TERM}},
    // zero byte acts as a high-precedence operator
    '{8'h00,    1'b0, 1'b1, 3'd0, '0},
    '{"e",      1'b0, 1'b1, 3'd1, {"e", CH_TERM, CH_TERM, CH_TERM}},
    '{CH_CLOSE, 1'b0, 1'b1, 3'd1, {8'h00, CH_TERM, CH_TERM, CH_TERM}},
    '{8'hFF,    1'b0, 1'b0, 3'd0, '0},
    // close with no open empties the stack, then close on an empty stack
    '{CH_CLOSE, 1'b0, 1'b1, 3'd2, {8'hFF, CH_MINUS, CH_TERM, CH_TERM}},
    '{CH_CLOSE, 1'b0, 1'b1, 3'd0, '0},
    // unmatched opens are flushed with the rest
    '{CH_OPEN,  1'b0, 1'b0, 3'd0, '0},
    '{CH_OPEN,  1'b0, 1'b0, 3'd0, '0},
    '{"f",      1'b1, 1'b1, 3'd4, {"f", CH_OPEN, CH_OPEN, CH_TERM}},
    // just outside the letter range
    '{8'h60,    1'b0, 1'b1, 3'd0, '0},
    '{8'h7B,    1'b0, 1'b1, 3'd1, {8'h60, CH_TERM, CH_TERM, CH_TERM}},
    '{"A",      1'b1, 1'b1, 3'd3, {8'h7B, "A", CH_TERM, CH_TERM}},
    '{CH_PLUS,  1'b1, 1'b1, 3'd2, {CH_PLUS, CH_TERM, CH_TERM, CH_TERM}},
    '{8'h80,    1'b1, 1'b1, 3'd2, {8'h80, CH_TERM, CH_TERM, CH_TERM}},
    '{CH_A,     1'b1, 1'b1, 3'd2, {CH_A, CH_TERM, CH_TERM, CH_TERM}},
    '{CH_CLOSE, 1'b1, 1'b1, 3'd1, {CH_TERM, CH_TERM, CH_TERM, CH_TERM}}
  };

  task automatic flag_mismatch(input string msg);
    mismatch_cnt++;
    $display("MISMATCH %s", msg);
  endtask

  function automatic void emit_char(input logic [7:0] ch);
    postfix_t r;
    r.symbol = ch;
    r.last   = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic logic [7:0] pop_op();
    op_depth--;
    return op_stack[op_depth];
  endfunction

  // a push onto a full stack is dropped
  function automatic void push_op(input logic [7:0] ch);
    if (op_depth < STACK_DEPTH) begin
      op_stack[op_depth] = ch;
      op_depth++;
    end
  endfunction

  // shunting-yard step: fills step_out with the postfix characters one symbol causes
  function automatic void shunt_symbol(input logic [7:0] sym, input logic eoe);
    sym_class_t cls;
    logic [7:0] t;
    step_out.delete();
    if (sym >= CH_A && sym <= CH_Z) cls = CLS_LETTER;
    else if (sym == CH_OPEN) cls = CLS_OPEN;
    else if (sym == CH_CLOSE) cls = CLS_CLOSE;
    else if (sym == CH_PLUS || sym == CH_MINUS) cls = CLS_ADDSUB;
    else cls = CLS_OTHER;
    case (cls)
      CLS_LETTER: emit_char(sym);
      CLS_OPEN: push_op(sym);
      CLS_CLOSE: begin
        while (op_depth > 0) begin
          t = pop_op();
          if (t == CH_OPEN) break;
          emit_char(t);
        end
      end
      CLS_ADDSUB: begin
        while (op_depth > 0 && op_stack[op_depth-1] != CH_OPEN) emit_char(pop_op());
        push_op(sym);
      end
      default: begin
        while (op_depth > 0 && op_stack[op_depth-1] != CH_OPEN &&
               op_stack[op_depth-1] != CH_PLUS && op_stack[op_depth-1] != CH_MINUS)
          emit_char(pop_op());
        push_op(sym);
      end
    endcase
    // end of expression: flush top first, then the terminator
    if (eoe) begin
      while (op_depth > 0) emit_char(pop_op());
      emit_char(CH_TERM);
    end
    if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_letter();
    return 8'(CH_A + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 7))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return "*";
      3: return "/";
      4: return "^";
      5: return "%";
      6: return "&";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // random well-formed expression appended to expr_buf
  function automatic void build_expr(input int lvl);
    int terms;
    terms = $urandom_range(1, 4);
    for (int i = 0; i < terms; i++) begin
      if (i > 0) expr_buf.push_back(pick_op());
      if (lvl < 5 && $urandom_range(0, 3) == 0) begin
        expr_buf.push_back(CH_OPEN);
        build_expr(lvl + 1);
        expr_buf.push_back(CH_CLOSE);
      end else begin
        expr_buf.push_back(rand_letter());
      end
    end
  endfunction

  // offer one symbol, wait for the transaction, then record what it should produce
  task automatic send_row(input drill_row_t row);
    int gap;
    postfix_t r;
    gap = send_burst ? 0 : idle_len();
    if (gap > 0) begin
      infix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    infix_ch.valid       <= 1'b1;
    infix_ch.symbol_in   <= row.sym;
    infix_ch.end_of_expr <= row.eoe;
    @(posedge clk);
    while (!infix_ch.ready) @(posedge clk);
    shunt_symbol(row.sym, row.eoe);
    if (row.typed) begin
      step_out.delete();
      for (int k = 0; k < row.nres; k++) begin
        r.symbol = row.res[k];
        r.last   = (k == row.nres - 1);
        step_out.push_back(r);
      end
    end
    foreach (step_out[k]) postfix_due.push_back(step_out[k]);
    items_sent++;
  endtask

  // stop offering and wait until every expected character has come out
  task automatic wait_drained();
    infix_ch.valid <= 1'b0;
    @(posedge clk);
    while (postfix_due.size() != 0) @(posedge clk);
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    postfix_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (choke_req) begin
        postfix_ch.ready <= 1'b0;
        repeat (CHOKE_CYCLES) @(posedge clk);
        choke_req = 1'b0;
      end else begin
        postfix_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        stall = sink_steady ? 0 : idle_len();
        if (stall > 0) begin
          postfix_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // compare each result transaction with the oldest expected character
  always @(posedge clk) begin
    postfix_t want;
    if (!rst && postfix_ch.valid && postfix_ch.ready) begin
      result_cnt++;
      if (postfix_due.size() == 0) begin
        flag_mismatch($sformatf("result %0d: unexpected symbol_out %02h",
                                result_cnt, postfix_ch.symbol_out));
      end else begin
        want = postfix_due.pop_front();
        if (postfix_ch.symbol_out !== want.symbol)
          flag_mismatch($sformatf("result %0d: symbol_out got %02h want %02h",
                                  result_cnt, postfix_ch.symbol_out, want.symbol));
        if (postfix_ch.last_of_run !== want.last)
          flag_mismatch($sformatf("result %0d: last_of_run got %b want %b",
                                  result_cnt, postfix_ch.last_of_run, want.last));
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // stimulus
  initial begin
    drill_row_t row;
    int         kind;
    int         pos;
    int         depth_n;
    int         last_idx;
    int         rand_start;
    bit         close_expr;
    bit         choke_done;
    rst                  <= 1'b1;
    infix_ch.valid       <= 1'b0;
    infix_ch.symbol_in   <= 8'h00;
    infix_ch.end_of_expr <= 1'b0;
    choke_done = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (drill_rows[i]) send_row(drill_rows[i]);
    wait_drained();

    // random expressions, mostly well formed
    rand_start = items_sent;
    while (items_sent - rand_start < RANDOM_ITEMS) begin
      expr_buf.delete();
      close_expr  = 1'b1;
      send_burst  = ($urandom_range(0, 4) == 0);
      sink_steady = ($urandom_range(0, 4) == 0);
      // long hold-off on the result side while symbols keep coming
      if (!choke_done && items_sent - rand_start >= 100) begin
        choke_req   = 1'b1;
        choke_done  = 1'b1;
        send_burst  = 1'b1;
        sink_steady = 1'b0;
      end
      kind = (items_sent == rand_start) ? 13 : $urandom_range(0, 19);
      if (kind < 13) begin
        build_expr(0);
      end else if (kind < 15) begin
        // deep nesting, can overfill the stack
        depth_n = $urandom_range(28, 40);
        repeat (depth_n) begin
          if ($urandom_range(0, 3) == 0) expr_buf.push_back(rand_letter());
          expr_buf.push_back(CH_OPEN);
        end
        expr_buf.push_back(rand_letter());
        if ($urandom_range(0, 1) == 1) begin
          expr_buf.push_back(pick_op());
          expr_buf.push_back(rand_letter());
        end
        repeat ($urandom_range(0, depth_n)) expr_buf.push_back(CH_CLOSE);
      end else if (kind < 18) begin
        // broken expression
        build_expr(0);
        pos = $urandom_range(0, expr_buf.size() - 1);
        case ($urandom_range(0, 3))
          0: expr_buf.delete(pos);
          1: expr_buf.insert(pos, 8'($urandom_range(0, 255)));
          2: expr_buf.insert(pos, CH_CLOSE);
          default: expr_buf.insert(pos, CH_OPEN);
        endcase
        if (expr_buf.size() == 0) expr_buf.push_back(rand_letter());
        close_expr = ($urandom_range(0, 3) != 0);
      end else begin
        // raw bytes
        repeat ($urandom_range(1, 8)) expr_buf.push_back(8'($urandom_range(0, 255)));
        close_expr = 1'($urandom_range(0, 1));
      end
      last_idx = expr_buf.size() - 1;
      foreach (expr_buf[k]) begin
        row = '{expr_buf[k], close_expr && (k == last_idx), 1'b0, 3'd0, '0};
        send_row(row);
      end
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && postfix_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/itp_pkg.sv
sv/itp_if.sv
sv/itp_ctrl.sv
sv/itp_datapath.sv
sv/infix_to_postfix_converter_unit.sv
tb/sv/tb.sv
